// ----- hw/rtl/fnvx_pkg.sv -----
package fnvx_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CNT_W  = 6;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_word FNV_BASIS = 32'd2166136261;
    localparam t_word FNV_PRIME = 32'd16777619;
    localparam int unsigned MIX_SHIFT = 13;
    localparam t_len  LEN_RESET = 7'd4;
    localparam t_len  MAX_OUT   = 7'd64;

    // xor of the four bytes of a word
    function automatic t_byte fold_bytes(input t_word h);
        return h[31:24] ^ h[23:16] ^ h[15:8] ^ h[7:0];
    endfunction

    // pre-multiply mix step
    function automatic t_word mix_word(input t_word h);
        return h ^ (h >> MIX_SHIFT);
    endfunction

    // clamp length to 1..64 and return count minus one
    function automatic t_cnt last_index(input t_len len);
        t_cnt idx;
        if (len == '0) begin
            idx = '0;
        end else if (len > MAX_OUT) begin
            idx = t_cnt'(MAX_OUT - 7'd1);
        end else begin
            idx = t_cnt'(len - 7'd1);
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/fnvx_if.sv -----
interface fnvx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fnvx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_byte;
    logic       last_out;

    modport source (output valid, output hash_byte, output last_out, input ready);
    modport sink   (input valid, input hash_byte, input last_out, output ready);
endinterface

interface fnvx_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] output_length;

    modport source (output valid, output output_length, input ready);
    modport sink   (input valid, input output_length, output ready);
endinterface

// ----- hw/rtl/fnvx_mul.sv -----
module fnvx_mul (
    input  logic            i_clk,
    input  logic            i_start,
    input  fnvx_pkg::t_word i_operand,
    output fnvx_pkg::t_word o_product
);
    import fnvx_pkg::*;

    t_word r_product;
    t_word n_product;

    // product modulo 2^32
    assign n_product = i_operand * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_product <= n_product;
        end
    end

    assign o_product = r_product;

endmodule

// ----- hw/rtl/fnv1a_id_hash_expander.sv -----
// FNV-1a identifier hash expander. Identifier bytes enter on i_in one beat at
// a time; each is xored into a 32-bit state that is then multiplied by the FNV
// prime. On the beat marked last_byte, output_length hash beats follow on o_out
// (0 counts as 1, above 64 as 64), the final one with last_out set, and the
// state returns to the offset basis. All multiplication runs through one shared
// registered multiplier: an identifier byte passes S_IDLE and S_ABSORB, and
// each hash beat S_MIX and S_EMIT, stalling while the sink holds ready low.
// i_in is not ready while a hash run is in progress. i_cfg writes output_length
// (reset 4) and is always ready; write it only while the block is idle.
module fnv1a_id_hash_expander (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fnvx_in_if.sink    i_in,
    fnvx_out_if.source o_out,
    fnvx_cfg_if.sink   i_cfg
);
    import fnvx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ABSORB,
        S_MIX,
        S_EMIT
    } t_state;

    t_state r_state;
    t_word  r_hash;
    logic   r_last;
    t_len   r_len;
    t_cnt   r_cnt;
    t_byte  r_out_byte;
    logic   r_out_last;
    logic   r_out_valid;

    logic   n_start;
    t_word  n_operand;
    t_word  w_product;
    logic   w_in_beat;
    logic   w_out_beat;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_beat   = i_in.valid && i_in.ready;
    assign w_out_beat  = r_out_valid && o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.hash_byte = r_out_byte;
    assign o_out.last_out  = r_out_last;

    always_comb begin
        n_start   = 1'b0;
        n_operand = r_hash ^ t_word'(i_in.data_byte);
        case (r_state)
            S_IDLE: begin
                n_start = w_in_beat;
            end
            S_ABSORB: begin
                n_start   = r_last;
                n_operand = mix_word(w_product);
            end
            S_EMIT: begin
                n_start   = w_out_beat && !r_out_last;
                n_operand = mix_word(r_hash);
            end
            default: begin
                n_start = 1'b0;
            end
        endcase
    end

    fnvx_mul u_mul (
        .i_clk     (i_clk),
        .i_start   (n_start),
        .i_operand (n_operand),
        .o_product (w_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= FNV_BASIS;
            r_last      <= 1'b0;
            r_len       <= LEN_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_len <= i_cfg.output_length;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_last  <= i_in.last_byte;
                        r_state <= S_ABSORB;
                    end
                end
                S_ABSORB: begin
                    r_hash <= w_product;
                    r_cnt  <= '0;
                    if (r_last) begin
                        r_state <= S_MIX;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MIX: begin
                    r_hash      <= w_product;
                    r_out_byte  <= fold_bytes(w_product);
                    r_out_last  <= (r_cnt == last_index(r_len));
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_beat) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_hash  <= FNV_BASIS;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + t_cnt'(1);
                            r_state <= S_MIX;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
